// File: src/fmps_pkg.sv
package fmps_pkg;

    // field widths fixed by the interface
    localparam int FUNC_W   = 2;
    localparam int SEL_W    = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int CAP_W    = 5;

    // build defaults
    localparam int NUM_STACKS_DEF  = 3;
    localparam int SLICE_DEPTH_DEF = 16;

    // capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PEEK = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } dp_cmd_t;

endpackage

// File: src/fmps_datapath.sv
module fmps_datapath #(
    parameter int NUM_STACKS  = fmps_pkg::NUM_STACKS_DEF,
    parameter int SLICE_DEPTH = fmps_pkg::SLICE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fmps_pkg::dp_cmd_t                   cmd,
    input  logic                                cfg_wr_en,
    input  logic [fmps_pkg::CAP_W-1:0]          cfg_wr_data,
    input  logic [fmps_pkg::FUNC_W-1:0]         s_func,
    input  logic [fmps_pkg::SEL_W-1:0]          s_stack_select,
    input  logic signed [fmps_pkg::DATA_W-1:0]  s_push_value,
    output logic signed [fmps_pkg::DATA_W-1:0]  m_read_value,
    output logic [fmps_pkg::STATUS_W-1:0]       m_status,
    output logic                                m_now_empty,
    output logic                                m_now_full
);
    import fmps_pkg::*;

    localparam int STORE_WORDS = NUM_STACKS * SLICE_DEPTH;
    localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int IDX_W       = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

    // capacity register
    logic [CAP_W-1:0] cap_reg;

    // captured request
    logic [FUNC_W-1:0] func_reg;
    logic [SEL_W-1:0]  sel_reg;
    logic [DATA_W-1:0] value_reg;

    // per stack entry counts
    logic [CAP_W-1:0] fill_reg [NUM_STACKS];

    // value store
    logic [DATA_W-1:0] store_mem [STORE_WORDS];
    logic [DATA_W-1:0] rdata_reg;

    // result registers
    logic                rd_ok_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                empty_reg;
    logic                full_reg;

    logic [CAP_W-1:0]    eff_cap;
    logic                sel_ok;
    logic [IDX_W-1:0]    idx;
    logic [CAP_W-1:0]    fill;
    logic                is_push;
    logic                is_read;
    logic                push_ok;
    logic                rd_ok;
    logic [CAP_W-1:0]    fill_next;
    logic [CAP_W-1:0]    slot_pos;
    logic [ADDR_W-1:0]   slot_addr;
    logic [STATUS_W-1:0] status_next;
    logic                empty_next;
    logic                full_next;
    logic                wr_en;

    // capacity above slice depth acts as slice depth
    assign eff_cap = (32'(cap_reg) > SLICE_DEPTH) ? CAP_W'(SLICE_DEPTH) : cap_reg;

    // decode of the captured request
    always_comb begin
        sel_ok    = (32'(sel_reg) < NUM_STACKS);
        idx       = sel_ok ? IDX_W'(sel_reg) : '0;
        fill      = fill_reg[idx];
        is_push   = (func_reg == FUNC_PUSH);
        is_read   = (func_reg == FUNC_POP) || (func_reg == FUNC_PEEK);
        push_ok   = sel_ok && is_push && (fill < eff_cap);
        rd_ok     = sel_ok && is_read && (fill != '0);
        fill_next = fill;
        if (push_ok) begin
            fill_next = fill + 1'b1;
        end else if (rd_ok && (func_reg == FUNC_POP)) begin
            fill_next = fill - 1'b1;
        end
        slot_pos  = is_push ? fill : (fill - 1'b1);
        slot_addr = ADDR_W'(int'(idx) * SLICE_DEPTH + int'(slot_pos));
        wr_en     = cmd.exec && push_ok;

        status_next = STAT_OK;
        if (is_push && !push_ok) begin
            status_next = STAT_FULL;
        end else if (is_read && !rd_ok) begin
            status_next = STAT_EMPTY;
        end
        empty_next = sel_ok ? (fill_next == '0) : 1'b1;
        full_next  = sel_ok ? (fill_next >= eff_cap) : 1'b1;
    end

    // configuration and fill counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
            for (int i = 0; i < NUM_STACKS; i++) begin
                fill_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.exec && sel_ok) begin
                fill_reg[idx] <= fill_next;
            end
        end
    end

    // request capture and result registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= s_func;
            sel_reg   <= s_stack_select;
            value_reg <= s_push_value;
        end
        if (cmd.exec) begin
            rd_ok_reg  <= rd_ok;
            status_reg <= status_next;
            empty_reg  <= empty_next;
            full_reg   <= full_next;
        end
    end

    // store: one write and one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[slot_addr] <= value_reg;
        end
        if (cmd.exec && rd_ok) begin
            rdata_reg <= store_mem[slot_addr];
        end
    end

    assign m_read_value = rd_ok_reg ? rdata_reg : '0;
    assign m_status     = status_reg;
    assign m_now_empty  = empty_reg;
    assign m_now_full   = full_reg;

    // a push only writes below the effective capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (fill < eff_cap))
        else $error("push written into full stack");

    // a good read never reports an error
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && rd_ok) |=> (status_reg == STAT_OK) && rd_ok_reg)
        else $error("read result flags inconsistent");

    // an absent stack reports both flags
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && !sel_ok) |=> (empty_reg && full_reg))
        else $error("absent stack flags wrong");

endmodule

// File: src/fmps_ctrl.sv
module fmps_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output fmps_pkg::dp_cmd_t cmd
);
    import fmps_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign cmd.load = s_valid && s_ready;
    assign cmd.exec = (state_reg == S_EXEC);

    // sequencer: capture, execute, hold result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    state_reg   <= S_RESP;
                    m_valid_reg <= 1'b1;
                end
                S_RESP: begin
                    if (m_ready) begin
                        state_reg   <= S_IDLE;
                        m_valid_reg <= 1'b0;
                    end
                end
                default: begin
                    state_reg   <= S_IDLE;
                    m_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    // only one request in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request accepted while result pending");

    // an accepted request executes on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> cmd.exec)
        else $error("accepted request not executed");

    // execution is followed by a valid result
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_valid)
        else $error("result missing after execution");

endmodule

// File: src/fixed_partition_multi_stack.sv
// sequence: a request is captured on acceptance, executed in S_EXEC, and its
//   result is held valid in S_RESP until m_ready takes it
// flow: no new request is accepted until the previous result has been taken,
//   since the sequencer raises s_ready only in S_IDLE
// reset: synchronous active low; all stacks empty, capacity 16,
//   store contents undefined until pushed
module fixed_partition_multi_stack #(
    parameter int NUM_STACKS  = fmps_pkg::NUM_STACKS_DEF,
    parameter int SLICE_DEPTH = fmps_pkg::SLICE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [fmps_pkg::CAP_W-1:0]          cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [fmps_pkg::FUNC_W-1:0]         s_func,
    input  logic [fmps_pkg::SEL_W-1:0]          s_stack_select,
    input  logic signed [fmps_pkg::DATA_W-1:0]  s_push_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [fmps_pkg::DATA_W-1:0]  m_read_value,
    output logic [fmps_pkg::STATUS_W-1:0]       m_status,
    output logic                                m_now_empty,
    output logic                                m_now_full
);
    import fmps_pkg::*;

    dp_cmd_t cmd;

    // sequencer
    fmps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // stacks, store and result registers
    fmps_datapath #(
        .NUM_STACKS  (NUM_STACKS),
        .SLICE_DEPTH (SLICE_DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_func         (s_func),
        .s_stack_select (s_stack_select),
        .s_push_value   (s_push_value),
        .m_read_value   (m_read_value),
        .m_status       (m_status),
        .m_now_empty    (m_now_empty),
        .m_now_full     (m_now_full)
    );

endmodule
